[hw/rtl/ebr_pkg.sv]
// Package: shared types, constants and command/status structs for the bisection root block.
package ebr_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned Q_W      = 31;
  localparam int unsigned TOL_W    = 16;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TOL  = 1'd1;

  localparam logic [AXIS_W-1:0] AXIS_TWO = 2'd2;

  // Sign of f(t).
  typedef enum logic [1:0] {
    SGN_NEG  = 2'd0,
    SGN_ZERO = 2'd1,
    SGN_POS  = 2'd2
  } sgn_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_EVAL_LO,
    ST_WAIT_LO,
    ST_EVAL_HI,
    ST_WAIT_HI,
    ST_CHECK,
    ST_EVAL_MID,
    ST_WAIT_MID,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Which point f is evaluated at.
  typedef enum logic [1:0] {
    PT_LO,
    PT_HI,
    PT_MID
  } point_t;

  typedef struct packed {
    logic   load;       // capture input item
    logic   sqrt_start; // start integer square root
    logic   eval_start; // start f evaluation
    point_t eval_pt;
    logic   set_inside; // result is inside
    logic   collapse_hi;// lo <= hi
    logic   update;     // apply mid evaluation
    logic   finish;     // compute final midpoint
  } ebr_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic eval_done;
    sgn_t sign;
    logic narrow;       // hi - lo <= tolerance
  } ebr_sts_t;

endpackage

[hw/rtl/ebr_stream_if.sv]
// Interfaces: valid/ready channels for input items, results and configuration writes.
interface ebr_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] p_x, p_y, p_z;
  logic [30:0] q_x, q_y, q_z;
  modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, input ready);
  modport sink   (input valid, p_x, p_y, p_z, q_x, q_y, q_z, output ready);
endinterface

interface ebr_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [30:0] root_value;
  logic        inside_flag;
  modport source (output valid, root_value, inside_flag, input ready);
  modport sink   (input valid, root_value, inside_flag, output ready);
endinterface

interface ebr_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/ebr_ctrl.sv]
// Controller: state machine sequencing square root, f evaluations and bisection steps.
module ebr_ctrl #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output ebr_pkg::ebr_cmd_t cmd,
  input  ebr_pkg::ebr_sts_t sts
);
  import ebr_pkg::*;

  localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    steps_nxt = steps_r;
    cmd       = '0;
    cmd.eval_pt = PT_LO;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_EVAL_LO;
      end
      ST_EVAL_LO: begin
        if (sts.sqrt_done) begin
          cmd.eval_start = 1'b1;
          cmd.eval_pt    = PT_LO;
          state_nxt      = ST_WAIT_LO;
        end
      end
      ST_WAIT_LO: begin
        if (sts.eval_done) begin
          if (sts.sign != SGN_POS) begin
            cmd.set_inside = 1'b1;
            state_nxt      = ST_OUT;
          end else begin
            state_nxt = ST_EVAL_HI;
          end
        end
      end
      ST_EVAL_HI: begin
        cmd.eval_start = 1'b1;
        cmd.eval_pt    = PT_HI;
        state_nxt      = ST_WAIT_HI;
      end
      ST_WAIT_HI: begin
        cmd.eval_pt = PT_HI;
        if (sts.eval_done) begin
          steps_nxt = '0;
          if (sts.sign == SGN_ZERO) begin
            cmd.collapse_hi = 1'b1;
            state_nxt       = ST_FINISH;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (steps_r == STEP_W'(MAX_STEPS) || sts.narrow) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_EVAL_MID;
        end
      end
      ST_EVAL_MID: begin
        cmd.eval_start = 1'b1;
        cmd.eval_pt    = PT_MID;
        state_nxt      = ST_WAIT_MID;
      end
      ST_WAIT_MID: begin
        cmd.eval_pt = PT_MID;
        if (sts.eval_done) begin
          cmd.update = 1'b1;
          steps_nxt  = steps_r + 1'b1;
          state_nxt  = (sts.sign == SGN_ZERO) ? ST_FINISH : ST_CHECK;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_io_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and result valid together");
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STEP_W'(MAX_STEPS)) else $error("step count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

[hw/rtl/ebr_datapath.sv]
// Datapath: operand registers, bracket, square root unit, shared divider and f accumulation.
module ebr_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [31:0]               in_p_x,
  input  logic [31:0]               in_p_y,
  input  logic [31:0]               in_p_z,
  input  logic [30:0]               in_q_x,
  input  logic [30:0]               in_q_y,
  input  logic [30:0]               in_q_z,
  input  logic [ebr_pkg::AXIS_W-1:0] axis_count,
  input  logic [ebr_pkg::TOL_W-1:0]  width_tolerance,
  input  ebr_pkg::ebr_cmd_t         cmd,
  output ebr_pkg::ebr_sts_t         sts,
  output logic [30:0]               root_value,
  output logic                      inside_flag
);
  import ebr_pkg::*;

  localparam int unsigned NUM_W = 32 + FRAC_BITS;   // dividend width
  localparam int unsigned DEN_W = 33;               // t + q
  localparam int unsigned DCNT_W = $clog2(NUM_W + 1);
  localparam logic [35:0] ONE = 36'(1) << FRAC_BITS;

  logic [31:0] mag_r [3];
  logic [30:0] q_r   [3];
  logic        three_r;
  logic [30:0] lo_r, hi_r, root_r;
  logic        inside_r;

  // ---- square root of sum of squares, one result bit per cycle
  logic [65:0] sq_v_r;
  logic [65:0] sq_r_r;
  logic [65:0] sq_bit_r;
  logic        sq_busy_r;
  logic [1:0]  sq_phase_r;  // accumulating squares over axes
  logic [63:0] prod_r;
  logic [1:0]  sq_ax_r;
  logic        sq_acc_r;

  function automatic logic [31:0] absval(input logic [31:0] v);
    absval = v[31] ? (32'd0 - v) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r[0] <= absval(in_p_x);
      mag_r[1] <= absval(in_p_y);
      mag_r[2] <= absval(in_p_z);
      q_r[0]   <= in_q_x;
      q_r[1]   <= in_q_y;
      q_r[2]   <= in_q_z;
      three_r  <= (axis_count != AXIS_TWO);
    end
  end

  logic [1:0] n_ax;
  assign n_ax = three_r ? 2'd3 : 2'd2;

  logic [65:0] sq_sum;
  assign sq_sum = sq_r_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r  <= 1'b0;
      sq_acc_r   <= 1'b0;
      sq_phase_r <= '0;
    end else if (cmd.sqrt_start) begin
      sq_acc_r <= 1'b1;
      sq_ax_r  <= 2'd0;
      sq_v_r   <= '0;
      sq_phase_r <= 2'd0;
    end else if (sq_acc_r) begin
      // One multiply, registered, then accumulate.
      if (sq_phase_r == 2'd0) begin
        prod_r     <= mag_r[sq_ax_r] * mag_r[sq_ax_r];
        sq_phase_r <= 2'd1;
      end else begin
        sq_v_r     <= sq_v_r + 66'(prod_r);
        sq_phase_r <= 2'd0;
        if (sq_ax_r == n_ax - 2'd1) begin
          sq_acc_r  <= 1'b0;
          sq_busy_r <= 1'b1;
          sq_r_r    <= '0;
          sq_bit_r  <= 66'(1) << 64;
        end else begin
          sq_ax_r <= sq_ax_r + 2'd1;
        end
      end
    end else if (sq_busy_r) begin
      if (sq_bit_r == '0) begin
        sq_busy_r <= 1'b0;
      end else begin
        if (sq_v_r >= sq_sum) begin
          sq_v_r <= sq_v_r - sq_sum;
          sq_r_r <= (sq_r_r >> 1) + sq_bit_r;
        end else begin
          sq_r_r <= sq_r_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
    end
  end

  logic sq_done;
  assign sq_done = !sq_acc_r && !sq_busy_r;

  // ---- f evaluation: one axis at a time through a restoring divider
  typedef enum logic [1:0] {EV_IDLE, EV_DIV, EV_SQ, EV_ACC} ev_t;
  ev_t         ev_r;
  logic [1:0]  ax_r;
  logic [30:0] t_r;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W:0]    rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [31:0]       rq_r;
  logic [63:0]       sqp_r;
  logic [35:0]       acc_r;
  logic              ev_done_r;

  logic [30:0] mid;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  logic [DEN_W:0] rem_sh;
  assign rem_sh = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};

  logic quo_ovf;
  assign quo_ovf = |num_r[NUM_W-1:32];

  logic [31:0] s_sat;
  assign s_sat = (|sqp_r[63:32+FRAC_BITS]) ? 32'hFFFF_FFFF : sqp_r[32+FRAC_BITS-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r      <= EV_IDLE;
      ev_done_r <= 1'b0;
    end else begin
      ev_done_r <= 1'b0;
      case (ev_r)
        EV_IDLE: begin
          if (cmd.eval_start) begin
            case (cmd.eval_pt)
              PT_LO:   t_r <= lo_r;
              PT_HI:   t_r <= hi_r;
              default: t_r <= mid;
            endcase
            ax_r  <= 2'd0;
            acc_r <= '0;
            ev_r  <= EV_ACC;
            dcnt_r <= '0;
          end
        end
        EV_ACC: begin
          // set up division for axis ax_r
          den_r  <= DEN_W'(t_r) + DEN_W'(q_r[ax_r]);
          num_r  <= NUM_W'(mag_r[ax_r]) << FRAC_BITS;
          rem_r  <= '0;
          dcnt_r <= DCNT_W'(NUM_W);
          ev_r   <= EV_DIV;
        end
        EV_DIV: begin
          if (den_r == '0) begin
            rq_r   <= (num_r == '0) ? 32'd0 : 32'hFFFF_FFFF;
            dcnt_r <= '0;
            ev_r   <= EV_SQ;
          end else if (dcnt_r == '0) begin
            rq_r <= quo_ovf ? 32'hFFFF_FFFF : num_r[31:0];
            ev_r <= EV_SQ;
          end else begin
            // num_r shifts out dividend bits and collects quotient bits.
            if (rem_sh >= {1'b0, den_r}) begin
              rem_r <= rem_sh - {1'b0, den_r};
              num_r <= {num_r[NUM_W-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              num_r <= {num_r[NUM_W-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        EV_SQ: begin
          if (dcnt_r == '0) begin
            sqp_r  <= rq_r * rq_r;
            dcnt_r <= DCNT_W'(1);
          end else begin
            acc_r <= acc_r + 36'(s_sat);
            if (ax_r == n_ax - 2'd1) begin
              ev_r      <= EV_IDLE;
              ev_done_r <= 1'b1;
            end else begin
              ax_r <= ax_r + 2'd1;
              ev_r <= EV_ACC;
            end
          end
        end
        default: ev_r <= EV_IDLE;
      endcase
    end
  end

  sgn_t sign;
  always_comb begin
    if (acc_r > ONE)       sign = SGN_POS;
    else if (acc_r == ONE) sign = SGN_ZERO;
    else                   sign = SGN_NEG;
  end

  // ---- bracket
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r     <= '0;
      inside_r <= 1'b0;
    end
    if (sq_busy_r && sq_bit_r == '0) begin
      hi_r <= (|sq_r_r[65:31]) ? 31'h7FFF_FFFF : sq_r_r[30:0];
    end
    if (cmd.set_inside) begin
      inside_r <= 1'b1;
      root_r   <= '0;
    end
    if (cmd.collapse_hi) lo_r <= hi_r;
    if (cmd.update) begin
      if (sign == SGN_ZERO) begin
        lo_r <= mid;
        hi_r <= mid;
      end else if (sign == SGN_POS) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.finish) root_r <= mid;
  end

  assign sts.sqrt_done = sq_done;
  assign sts.eval_done = ev_done_r;
  assign sts.sign      = sign;
  assign sts.narrow    = (hi_r - lo_r) <= 31'(width_tolerance);

  assign root_value  = root_r;
  assign inside_flag = inside_r;

  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    ev_done_r |-> lo_r <= hi_r || inside_r) else $error("bracket inverted");
  a_ax: assert property (@(posedge clk) disable iff (!rst_n)
    ev_r != EV_IDLE |-> ax_r < n_ax) else $error("axis index out of range");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    ev_done_r |-> $past(ev_r) == EV_SQ) else $error("spurious evaluation done");

endmodule

[hw/rtl/ellipsoid_bisection_root_top.sv]
// Top level: bisection root finder for the ellipsoid distance secular equation.
// Each accepted input transfer carries per-axis products p and squared semi-axes q
// in Q16.16. The block sums the squares of |p| over two or three axes (axis_count
// register), takes an integer square root one result bit per cycle to set the upper
// end of the bracket, then evaluates the sign of f(t) = sum (p/(t+q))^2 - 1 at the low
// end. If f(0) is not positive, one result transfer reports inside_flag with a zero
// root. Otherwise the bracket is halved until its width is at most width_tolerance,
// MAX_STEPS halvings are done or f is exactly zero at hi or at a midpoint, and the
// final midpoint is returned. One item is worked at a time. Each f evaluation runs
// the axes through one shared restoring divider, one quotient bit per cycle, with a
// setup, square and accumulate step per axis. An item that is not inside takes the
// square root plus (2 + steps) evaluations. Configuration writes are accepted at
// any time and must only be made while the block is idle.
module ellipsoid_bisection_root_top #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MAX_STEPS = 64
) (
  input logic     clk,
  input logic     rst_n,
  ebr_in_if.sink  in_ch,
  ebr_out_if.source out_ch,
  ebr_cfg_if.sink cfg_ch
);
  import ebr_pkg::*;

  logic [AXIS_W-1:0] axis_count_r;
  logic [TOL_W-1:0]  width_tol_r;
  ebr_cmd_t cmd;
  ebr_sts_t sts;

  // Configuration registers are always ready.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= 2'd3;
      width_tol_r  <= 16'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_AXIS_COUNT: axis_count_r <= cfg_ch.data[AXIS_W-1:0];
        REG_WIDTH_TOL:  width_tol_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  ebr_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd, .sts
  );

  ebr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n,
    .in_p_x(in_ch.p_x), .in_p_y(in_ch.p_y), .in_p_z(in_ch.p_z),
    .in_q_x(in_ch.q_x), .in_q_y(in_ch.q_y), .in_q_z(in_ch.q_z),
    .axis_count     (axis_count_r),
    .width_tolerance(width_tol_r),
    .cmd, .sts,
    .root_value (out_ch.root_value),
    .inside_flag(out_ch.inside_flag)
  );

  a_cfg_rst: assert property (@(posedge clk) $fell(rst_n) |=> axis_count_r == 2'd3)
    else $error("axis count reset value");
  a_inside_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.inside_flag |-> out_ch.root_value == '0)
    else $error("inside result with nonzero root");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("second item taken");

endmodule

[tb/ebr_result_checker.sv]
`timescale 1ns / 1ps
// Result checker: tracks register writes, predicts each bisection result and compares.
module ebr_result_checker
  import ebr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic clk,
  input  logic rst_n,
  ebr_in_if    in_mon,
  ebr_out_if   out_mon,
  ebr_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   roots_seen,
  output int   inside_seen
);

  typedef struct packed {
    logic [30:0] root_value;
    logic        inside_flag;
  } root_t;

  localparam longint unsigned SAT32 = 64'hFFFF_FFFF;
  localparam longint unsigned SAT31 = 64'h7FFF_FFFF;

  root_t          expected_roots[$];
  logic [1:0]     axis_sel;
  logic [15:0]    tol_lsbs;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Sign of sum (|p|/(t+q))^2 - 1 with the block's saturation rules.
  function automatic sgn_t secular_sign(input longint unsigned mag[3],
                                        input longint unsigned qv[3],
                                        input int n, input longint unsigned t);
    longint unsigned acc;
    longint unsigned d;
    longint unsigned r;
    longint unsigned s;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      d = t + qv[i];
      if (d == 0) begin
        r = (mag[i] == 0) ? 0 : SAT32;
      end else begin
        r = (mag[i] << FRAC_BITS) / d;
        if (r > SAT32) r = SAT32;
      end
      s = (r * r) >> FRAC_BITS;
      if (s > SAT32) s = SAT32;
      acc = acc + s;
    end
    if (acc > (64'd1 << FRAC_BITS)) return SGN_POS;
    if (acc == (64'd1 << FRAC_BITS)) return SGN_ZERO;
    return SGN_NEG;
  endfunction

  function automatic root_t ebr_root_predict(input logic [31:0] p[3],
                                             input logic [30:0] q[3]);
    longint unsigned mag[3];
    longint unsigned qv[3];
    longint unsigned sumsq;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    sgn_t            s;
    int              n;
    root_t           res;
    n = (axis_sel == AXIS_TWO) ? 2 : 3;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = p[i][31] ? (64'h1_0000_0000 - {32'd0, p[i]}) : {32'd0, p[i]};
      qv[i]  = {33'd0, q[i]};
    end
    for (int i = 0; i < n; i++) sumsq = sumsq + mag[i] * mag[i];
    hi = int_sqrt(sumsq);
    if (hi > SAT31) hi = SAT31;
    lo = 0;
    res = '0;
    if (secular_sign(mag, qv, n, lo) != SGN_POS) begin
      res.inside_flag = 1'b1;
      return res;
    end
    if (secular_sign(mag, qv, n, hi) == SGN_ZERO) begin
      lo = hi;
    end else begin
      for (int k = 0; k < MAX_STEPS; k++) begin
        if (hi - lo <= {48'd0, tol_lsbs}) break;
        mid = lo + ((hi - lo) >> 1);
        s = secular_sign(mag, qv, n, mid);
        if (s == SGN_ZERO) begin
          lo = mid;
          hi = mid;
          break;
        end
        if (s == SGN_POS) lo = mid;
        else hi = mid;
      end
    end
    mid = lo + ((hi - lo) >> 1);
    res.root_value = mid[30:0];
    return res;
  endfunction

  assign pending = expected_roots.size();

  always @(posedge clk) begin
    root_t got;
    root_t want;
    int    errs;
    errs = 0;
    if (!rst_n) begin
      axis_sel    <= 2'd3;
      tol_lsbs    <= 16'd1;
      fail_count  <= 0;
      roots_seen  <= 0;
      inside_seen <= 0;
      expected_roots.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_AXIS_COUNT) axis_sel <= cfg_mon.data[1:0];
        else tol_lsbs <= cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready)
        expected_roots.push_back(ebr_root_predict('{in_mon.p_x, in_mon.p_y, in_mon.p_z},
                                                  '{in_mon.q_x, in_mon.q_y, in_mon.q_z}));
      if (out_mon.valid && out_mon.ready) begin
        got.root_value  = out_mon.root_value;
        got.inside_flag = out_mon.inside_flag;
        roots_seen  <= roots_seen + 1;
        inside_seen <= inside_seen + got.inside_flag;
        if (expected_roots.size() == 0) begin
          $error("unexpected result transfer: root_value %0d inside_flag %0d",
                 got.root_value, got.inside_flag);
          errs = errs + 1;
        end else begin
          want = expected_roots.pop_front();
          if (got.root_value !== want.root_value) begin
            $error("root_value: expected %0d, got %0d", want.root_value, got.root_value);
            errs = errs + 1;
          end
          if (got.inside_flag !== want.inside_flag) begin
            $error("inside_flag: expected %0d, got %0d", want.inside_flag,
                   got.inside_flag);
            errs = errs + 1;
          end
        end
        if (errs != 0) fail_count <= fail_count + errs;
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus for the bisection root block and the verdict.
module tb_top;
  import ebr_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count, pending, roots_seen, inside_seen;

  // When set, neither side inserts idle cycles; used for the closing stretch of the run.
  bit   quiet;
  // Request for one long receiver hold-off; the receiver process clears it when done.
  bit   hold_req;
  int   items_sent;

  ebr_in_if  in_ch  (clk);
  ebr_out_if out_ch (clk);
  ebr_cfg_if cfg_ch (clk);

  ellipsoid_bisection_root_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ebr_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .roots_seen  (roots_seen),
    .inside_seen (inside_seen)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard limit: far above the slowest legal run (every item at full step count with
  // the longest stalls on both sides).
  initial begin
    #400_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stall bursts, stretches of steady acceptance, and on request
  // one long hold-off while the sender keeps offering items.
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (6000) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One configuration transfer; callers only use this while the block is idle.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offers one item and returns after its transfer. Valid stays high into the next
  // item unless an idle burst is drawn, so back-to-back offers are exercised too.
  task automatic send_item(input logic [31:0] px, py, pz, input logic [30:0] qx, qy, qz);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.p_x <= px;
    in_ch.p_y <= py;
    in_ch.p_z <= pz;
    in_ch.q_x <= qx;
    in_ch.q_y <= qy;
    in_ch.q_z <= qz;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic settle;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // Random p: mostly modest magnitudes so the bracket stays short, sometimes full range.
  function automatic logic [31:0] rand_p(input int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom_range(0, 32'h0004_0000);
      1: v = $urandom_range(0, 32'h0100_0000);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Random q: zero at times so the zero-divisor paths see traffic.
  function automatic logic [30:0] rand_q(input int mode);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 31'($urandom);
      default: return (mode == 0) ? 31'($urandom_range(0, 32'h0004_0000))
                                  : 31'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  task automatic random_items(input int count);
    int mode;
    for (int k = 0; k < count; k++) begin
      mode = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 3) == 0) ? 2 : 1);
      send_item(rand_p(mode), rand_p(mode), rand_p(mode),
                rand_q(mode), rand_q(mode), rand_q(mode));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    items_sent   = 0;
    in_ch.valid  = 1'b0;
    in_ch.p_x    = '0;
    in_ch.p_y    = '0;
    in_ch.p_z    = '0;
    in_ch.q_x    = '0;
    in_ch.q_y    = '0;
    in_ch.q_z    = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_AXIS_COUNT;
    cfg_ch.data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items under the reset settings: three axes, tolerance of one LSB.
    // All zero: every quotient is zero over zero, so the point counts as inside.
    send_item(32'd0, 32'd0, 32'd0, 31'd0, 31'd0, 31'd0);
    // A nonzero p over a zero divisor saturates the quotient and square.
    send_item(32'h0001_0000, 32'd0, 32'd0, 31'd0, 31'd5, 31'd0);
    // Unit p with zero q: the root lands exactly on the upper end of the bracket.
    send_item(32'h0001_0000, 32'd0, 32'd0, 31'd0, 31'd0, 31'd0);
    send_item(32'd0, 32'hFFFF_0000, 32'd0, 31'd0, 31'd0, 31'd0);
    // Candidates for an exact hit at a midpoint.
    send_item(32'h0003_0000, 32'd0, 32'd0, 31'h0001_0000, 31'd0, 31'd0);
    send_item(32'h0002_0000, 32'd0, 32'd0, 31'd0, 31'd0, 31'd0);
    // Field extremes.
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0, 31'd0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'd1, 31'h7FFF_FFFF, 31'd0);
    send_item(32'hFFFF_FFFF, 32'd1, 32'd0, 31'd0, 31'd0, 31'd0);
    // Inside and on the surface.
    send_item(32'h0000_8000, 32'h0000_8000, 32'd0, 31'h0001_0000, 31'h0001_0000, 31'd1);
    send_item(32'h0001_0000, 32'd0, 32'd0, 31'h0001_0000, 31'd0, 31'd0);
    // Upper end: small q still leaves f(hi) below zero; tiny p leaves it above zero.
    send_item(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 31'd3, 31'd7, 31'd1);
    send_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 31'd0, 31'd0, 31'd0);
    settle();

    // Two axes with the z fields set to values that would matter for three.
    write_reg(REG_AXIS_COUNT, 16'd2);
    send_item(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 31'h0001_0000, 31'd0, 31'd0);
    send_item(32'd0, 32'd0, 32'h0100_0000, 31'd0, 31'd0, 31'd0);
    random_items(90);
    settle();

    // Widest tolerance, three axes, including the long receiver hold-off: the block
    // finishes one item, cannot hand it over, and the sender stalls behind it.
    write_reg(REG_AXIS_COUNT, 16'd3);
    write_reg(REG_WIDTH_TOL, 16'hFFFF);
    hold_req = 1'b1;
    random_items(90);
    settle();

    write_reg(REG_AXIS_COUNT, 16'd2);
    random_items(90);
    settle();

    // Axis counts other than two mean three axes.
    write_reg(REG_AXIS_COUNT, 16'd0);
    write_reg(REG_WIDTH_TOL, 16'd300);
    random_items(80);
    settle();

    write_reg(REG_AXIS_COUNT, 16'd1);
    write_reg(REG_WIDTH_TOL, 16'd40);
    random_items(80);
    settle();

    // Closing stretch at the tightest tolerance with no idling on either side.
    write_reg(REG_AXIS_COUNT, 16'd3);
    write_reg(REG_WIDTH_TOL, 16'd1);
    quiet = 1'b1;
    random_items(130);
    @(negedge clk);
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("Run covered %0d items over two- and three-axis settings and tolerances",
             items_sent);
    $display("from 1 to 65535 LSBs; %0d results checked, %0d of them inside.",
             roots_seen, inside_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
